FILE: rtl/assert_macros.svh
// Assertion helpers shared by the top, divider and controller files.
// Each macro takes a label, the clock, the reset, the property terms and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RBED_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define RBED_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RBED_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RBED_ASSERT(lbl, clk, rst, prop, msg)
`define RBED_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define RBED_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/rbed_pkg.sv
package rbed_pkg;

   // Raw envelope store geometry.
   localparam int RAW_DEPTH = 64;
   localparam int RAW_AW    = $clog2(RAW_DEPTH);
   localparam int LEN_W     = $clog2(RAW_DEPTH + 1);
   localparam int ENV_BINS  = 8;
   localparam int BIN_W     = $clog2(ENV_BINS);

   // Shared divider widths.
   localparam int DVD_W = 16;
   localparam int DVS_W = 9;

   // Stream widths.
   localparam int REQ_TDATA_W = 56;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 136;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // Clamp ceiling of a margin and the slot width limit for doubling.
   localparam logic [7:0] MARGIN_MAX     = 8'd255;
   localparam logic [7:0] SPS_DOUBLE_MAX = 8'd64;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_ENTER_MARGIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_EXIT_MARGIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TAIL         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_BURST    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_BURST    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BAND         = 3'd5;

   typedef struct packed {
      logic [7:0]  enter_margin_db;
      logic [7:0]  exit_margin_db;
      logic [15:0] tail_ms;
      logic [15:0] min_burst_ms;
      logic [15:0] max_burst_ms;
      logic [2:0]  band_id;
   } cfg_type;

   typedef struct packed {
      logic              operation;
      logic              sample_valid;
      logic signed [9:0] signal_dbm;
      logic signed [9:0] noise_lvl;
      logic [31:0]       time_ms;
   } item_type;

   typedef struct packed {
      logic              valid;
      logic [31:0]       start_ms;
      logic [15:0]       duration_ms;
      logic signed [9:0] top_sig_lvl;
      logic signed [9:0] open_noise_lvl;
      logic [2:0]        band;
      logic [63:0]       envelope;
   } result_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: rtl/rf_burst_envelope_detector_top.sv
// Channel | Direction | Contents
// req_    | in        | one RSSI sample or flush command per item
// rsp_    | out       | one burst report per item when a valid burst closes
// csr_    | in        | register writes, index and data
//
// An ignored or cold sample is only evaluated, and a warm one also joins the slot sum;
// one that completes a slot goes through the shared 16-step divider, after a fold if full.
// A close walks the store bin by bin, through the single RAM read port and the
// divider; the report then sits in the output register.
// Reset is synchronous and active high; the store needs no clearing pass.
// A stalled report holds the block only when a second report is ready.
`include "assert_macros.svh"

module rf_burst_envelope_detector_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // signal_dbm, noise_lvl, time_ms, zero pad
   input  logic [rbed_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // operation, sample_valid
   input  logic [rbed_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // start_ms, duration_ms, top_sig_lvl, open_noise_lvl, band, envelope, zero pad
   output logic [rbed_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                               csr_we,
   input  logic [rbed_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rbed_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   rbed_pkg::cfg_type    cfg_ff, cfg_in;
   rbed_pkg::item_type   item;
   rbed_pkg::result_type res;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [rbed_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                 out_ready;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            rbed_pkg::REG_ENTER_MARGIN: cfg_in.enter_margin_db = csr_wdata[7:0];
            rbed_pkg::REG_EXIT_MARGIN:  cfg_in.exit_margin_db  = csr_wdata[7:0];
            rbed_pkg::REG_TAIL:         cfg_in.tail_ms         = csr_wdata;
            rbed_pkg::REG_MIN_BURST:    cfg_in.min_burst_ms    = csr_wdata;
            rbed_pkg::REG_MAX_BURST:    cfg_in.max_burst_ms    = csr_wdata;
            rbed_pkg::REG_BAND:         cfg_in.band_id         = csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   // Unpack the input item.
   assign item.operation    = req_tuser[0];
   assign item.sample_valid = req_tuser[1];
   assign item.signal_dbm   = req_tdata[9:0];
   assign item.noise_lvl    = req_tdata[19:10];
   assign item.time_ms      = req_tdata[51:20];

   rbed_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .item(item),
      .res(res),
      .out_ready(out_ready)
   );

   // Output register decouples the report from the consumer.
   assign out_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_ready) begin
         rsp_valid_in = res.valid;
         rsp_data_in  = {1'b0, res.envelope, res.band, res.open_noise_lvl,
                         res.top_sig_lvl, res.duration_ms, res.start_ms};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enter_margin_db <= 8'd9;
         cfg_ff.exit_margin_db  <= 8'd4;
         cfg_ff.tail_ms         <= 16'd8;
         cfg_ff.min_burst_ms    <= 16'd4;
         cfg_ff.max_burst_ms    <= 16'd300;
         cfg_ff.band_id         <= 3'd2;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `RBED_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "second item taken while first in work")

endmodule

FILE: rtl/rbed_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
module rbed_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/rbed_div.sv
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle.
module rbed_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rbed_pkg::div_req_type req,
   output rbed_pkg::div_rsp_type rsp
);

   localparam int CNT_W = $clog2(rbed_pkg::DVD_W);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [rbed_pkg::DVS_W-1:0] rem_ff, rem_in;
   logic [rbed_pkg::DVD_W-1:0] quo_ff, quo_in;
   logic [rbed_pkg::DVS_W-1:0] dvs_ff, dvs_in;
   logic [rbed_pkg::DVS_W:0]   shifted;
   logic                       fits;

   // One restoring step on the partial remainder.
   assign shifted = {rem_ff, quo_ff[rbed_pkg::DVD_W-1]};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? rbed_pkg::DVS_W'(shifted - {1'b0, dvs_ff})
                       : shifted[rbed_pkg::DVS_W-1:0];
         quo_in = {quo_ff[rbed_pkg::DVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(rbed_pkg::DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   `RBED_ASSERT_IMP(a_start_idle, clock, reset, req.start, !busy_ff, "divider started while busy")

endmodule

FILE: rtl/rbed_ctrl.sv
`include "assert_macros.svh"

// Burst tracker: per-item decisions, slot averaging, store folding and
// envelope reduction around the raw envelope RAM and the shared divider.
module rbed_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  rbed_pkg::cfg_type    cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rbed_pkg::item_type   item,
   output rbed_pkg::result_type res,
   input  logic                 out_ready
);

   localparam int LW = rbed_pkg::LEN_W;
   localparam int AW = rbed_pkg::RAW_AW;
   localparam int PW = rbed_pkg::LEN_W + 4;

   typedef enum logic [4:0] {
      ST_IDLE, ST_EVAL, ST_ACC, ST_FOLD_RD0, ST_FOLD_RD1, ST_FOLD_WR,
      ST_SLOT_DIV, ST_SLOT_WAIT, ST_CLOSE, ST_CLOSE_CHK, ST_BIN, ST_BIN_RD,
      ST_BIN_ACC, ST_BIN_DIV, ST_BIN_WAIT, ST_NORM_DIV, ST_NORM_WAIT, ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   // Burst state.
   rbed_pkg::item_type item_ff, item_in;
   logic               open_ff, open_in;
   logic               supp_ff, supp_in;
   logic [31:0]        start_ff, start_in;
   logic [31:0]        warm_ff, warm_in;
   logic signed [9:0]  peak_ff, peak_in;
   logic signed [9:0]  flr_ff, flr_in;
   logic [LW-1:0]      len_ff, len_in;
   logic [7:0]         sps_ff, sps_in;
   logic [7:0]         fill_ff, fill_in;
   logic [15:0]        sum_ff, sum_in;

   // Working registers.
   logic [7:0]               m_ff, m_in;
   logic                     closing_ff, closing_in;
   logic [LW-1:0]            idx_ff, idx_in;
   logic [LW-1:0]            lo_ff, lo_in;
   logic [LW-1:0]            hi_ff, hi_in;
   logic [rbed_pkg::BIN_W-1:0] bin_ff, bin_in;
   logic [15:0]              bsum_ff, bsum_in;
   logic [7:0]               half_ff, half_in;
   logic [7:0]               v_ff [rbed_pkg::ENV_BINS];
   logic [7:0]               v_in [rbed_pkg::ENV_BINS];
   logic [7:0]               bpeak_ff, bpeak_in;
   logic [63:0]              env_ff, env_in;

   // Memory and divider ports.
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [7:0]            ram_wdata, ram_rdata;
   rbed_pkg::div_req_type div_req;
   rbed_pkg::div_rsp_type div_rsp;

   // Decision terms of one sample.
   logic signed [10:0] margin;
   logic               hot, warm, quiet, over, dur_ok;
   logic [7:0]         clamped;
   logic [31:0]        t, dur;
   logic [15:0]        acc_sum;
   logic [7:0]         acc_fill, q8;
   logic [PW-1:0]      lo_prod, hi_prod;
   logic [LW-1:0]      lo_raw, hi_raw, hi_adj, hi_bin, lo_bin, idx_nxt;
   logic [8:0]         pair_sum;

   rbed_ram #(.WIDTH(8), .DEPTH(rbed_pkg::RAW_DEPTH)) u_store (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   rbed_div u_div (
      .clock(clock),
      .reset(reset),
      .req(div_req),
      .rsp(div_rsp)
   );

   assign t      = item_ff.time_ms;
   assign margin = 11'(item_ff.signal_dbm) - 11'(item_ff.noise_lvl);
   assign hot    = margin >= $signed({3'b000, cfg.enter_margin_db});
   assign warm   = margin >= $signed({3'b000, cfg.exit_margin_db});
   assign quiet  = (t - warm_ff) >= {16'd0, cfg.tail_ms};
   assign over   = (t - start_ff) > {16'd0, cfg.max_burst_ms};
   assign dur    = warm_ff - start_ff;
   assign dur_ok = !(dur < {16'd0, cfg.min_burst_ms}) && !(dur > {16'd0, cfg.max_burst_ms});

   // Margin clamped to a byte.
   always_comb begin
      if (margin[10]) begin
         clamped = 8'd0;
      end else if (margin[9:8] != 2'b00) begin
         clamped = rbed_pkg::MARGIN_MAX;
      end else begin
         clamped = margin[7:0];
      end
   end

   assign acc_sum  = sum_ff + {8'd0, m_ff};
   assign acc_fill = fill_ff + 8'd1;
   assign q8       = div_rsp.quotient[7:0];
   assign idx_nxt  = idx_ff + 1'b1;
   assign pair_sum = {1'b0, half_ff} + {1'b0, ram_rdata};

   // Slice bounds of the current envelope bin.
   assign lo_prod = PW'(bin_ff) * PW'(len_ff);
   assign hi_prod = PW'({1'b0, bin_ff} + 4'd1) * PW'(len_ff);
   assign lo_raw  = lo_prod[LW+2:3];
   assign hi_raw  = hi_prod[LW+2:3];
   assign hi_adj  = (hi_raw <= lo_raw) ? LW'(lo_raw + 1'b1) : hi_raw;
   assign hi_bin  = (hi_adj > len_ff) ? len_ff : hi_adj;
   assign lo_bin  = (lo_raw >= len_ff) ? LW'(len_ff - 1'b1) : lo_raw;

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      open_in    = open_ff;
      supp_in    = supp_ff;
      start_in   = start_ff;
      warm_in    = warm_ff;
      peak_in    = peak_ff;
      flr_in     = flr_ff;
      len_in     = len_ff;
      sps_in     = sps_ff;
      fill_in    = fill_ff;
      sum_in     = sum_ff;
      m_in       = m_ff;
      closing_in = closing_ff;
      idx_in     = idx_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      bin_in     = bin_ff;
      bsum_in    = bsum_ff;
      half_in    = half_ff;
      v_in       = v_ff;
      bpeak_in   = bpeak_ff;
      env_in     = env_ff;
      ram_we     = 1'b0;
      ram_waddr  = '0;
      ram_wdata  = '0;
      ram_raddr  = '0;
      div_req    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               item_in  = item;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_IDLE;
            if (item_ff.operation) begin
               if (open_ff) begin
                  if (t > warm_ff) begin
                     warm_in = t;
                  end
                  state_in = ST_CLOSE;
               end
            end else if (item_ff.sample_valid) begin
               if (!open_ff) begin
                  if (supp_ff) begin
                     if (warm) begin
                        warm_in = t;
                     end else if (quiet) begin
                        supp_in = 1'b0;
                     end
                  end else if (hot) begin
                     open_in    = 1'b1;
                     start_in   = t;
                     warm_in    = t;
                     peak_in    = item_ff.signal_dbm;
                     flr_in     = item_ff.noise_lvl;
                     len_in     = '0;
                     sps_in     = 8'd1;
                     fill_in    = '0;
                     sum_in     = '0;
                     m_in       = clamped;
                     closing_in = 1'b0;
                     state_in   = ST_ACC;
                  end
               end else begin
                  if (item_ff.signal_dbm > peak_ff) begin
                     peak_in = item_ff.signal_dbm;
                  end
                  if (!warm && quiet) begin
                     state_in = ST_CLOSE;
                  end else begin
                     if (warm) begin
                        warm_in    = t;
                        m_in       = clamped;
                        closing_in = 1'b0;
                        state_in   = ST_ACC;
                     end
                     if (over) begin
                        open_in = 1'b0;
                        supp_in = 1'b1;
                     end
                  end
               end
            end
         end
         ST_ACC: begin
            sum_in  = acc_sum;
            fill_in = acc_fill;
            if (acc_fill < sps_ff) begin
               state_in = ST_IDLE;
            end else if (len_ff >= LW'(rbed_pkg::RAW_DEPTH)) begin
               idx_in   = '0;
               state_in = ST_FOLD_RD0;
            end else begin
               state_in = ST_SLOT_DIV;
            end
         end
         ST_FOLD_RD0: begin
            ram_raddr = {idx_ff[AW-2:0], 1'b0};
            state_in  = ST_FOLD_RD1;
         end
         ST_FOLD_RD1: begin
            ram_raddr = {idx_ff[AW-2:0], 1'b1};
            half_in   = ram_rdata;
            state_in  = ST_FOLD_WR;
         end
         ST_FOLD_WR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff[AW-1:0];
            ram_wdata = pair_sum[8:1];
            idx_in    = idx_nxt;
            if (idx_nxt == (len_ff >> 1)) begin
               len_in = len_ff >> 1;
               if (sps_ff <= rbed_pkg::SPS_DOUBLE_MAX) begin
                  sps_in = sps_ff << 1;
               end
               state_in = ST_SLOT_DIV;
            end else begin
               state_in = ST_FOLD_RD0;
            end
         end
         ST_SLOT_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = sum_ff;
            div_req.divisor  = {1'b0, fill_ff};
            state_in         = ST_SLOT_WAIT;
         end
         ST_SLOT_WAIT: begin
            if (div_rsp.done) begin
               ram_we    = 1'b1;
               ram_waddr = len_ff[AW-1:0];
               ram_wdata = q8;
               len_in    = len_ff + 1'b1;
               sum_in    = '0;
               fill_in   = '0;
               state_in  = closing_ff ? ST_CLOSE_CHK : ST_IDLE;
            end
         end
         ST_CLOSE: begin
            open_in = 1'b0;
            if (fill_ff != 8'd0 && len_ff < LW'(rbed_pkg::RAW_DEPTH)) begin
               closing_in = 1'b1;
               state_in   = ST_SLOT_DIV;
            end else begin
               state_in = ST_CLOSE_CHK;
            end
         end
         ST_CLOSE_CHK: begin
            closing_in = 1'b0;
            if (!dur_ok) begin
               state_in = ST_IDLE;
            end else if (len_ff == '0) begin
               env_in   = '0;
               state_in = ST_EMIT;
            end else begin
               bin_in   = '0;
               bpeak_in = '0;
               state_in = ST_BIN;
            end
         end
         ST_BIN: begin
            idx_in   = lo_bin;
            lo_in    = lo_bin;
            hi_in    = hi_bin;
            bsum_in  = '0;
            state_in = ST_BIN_RD;
         end
         ST_BIN_RD: begin
            ram_raddr = idx_ff[AW-1:0];
            state_in  = ST_BIN_ACC;
         end
         ST_BIN_ACC: begin
            bsum_in  = bsum_ff + {8'd0, ram_rdata};
            idx_in   = idx_nxt;
            state_in = (idx_nxt == hi_ff) ? ST_BIN_DIV : ST_BIN_RD;
         end
         ST_BIN_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = bsum_ff;
            div_req.divisor  = rbed_pkg::DVS_W'(hi_ff - lo_ff);
            state_in         = ST_BIN_WAIT;
         end
         ST_BIN_WAIT: begin
            if (div_rsp.done) begin
               v_in[bin_ff] = q8;
               if (q8 > bpeak_ff) begin
                  bpeak_in = q8;
               end
               if (bin_ff == rbed_pkg::BIN_W'(rbed_pkg::ENV_BINS - 1)) begin
                  bin_in = '0;
                  if (q8 == 8'd0 && bpeak_ff == 8'd0) begin
                     env_in   = '0;
                     state_in = ST_EMIT;
                  end else begin
                     state_in = ST_NORM_DIV;
                  end
               end else begin
                  bin_in   = bin_ff + 1'b1;
                  state_in = ST_BIN;
               end
            end
         end
         ST_NORM_DIV: begin
            // Scale by 255 as a shift and subtract.
            div_req.start    = 1'b1;
            div_req.dividend = {v_ff[bin_ff], 8'd0} - {8'd0, v_ff[bin_ff]};
            div_req.divisor  = {1'b0, bpeak_ff};
            state_in         = ST_NORM_WAIT;
         end
         ST_NORM_WAIT: begin
            if (div_rsp.done) begin
               env_in[{bin_ff, 3'b000} +: 8] = q8;
               if (bin_ff == rbed_pkg::BIN_W'(rbed_pkg::ENV_BINS - 1)) begin
                  state_in = ST_EMIT;
               end else begin
                  bin_in   = bin_ff + 1'b1;
                  state_in = ST_NORM_DIV;
               end
            end
         end
         ST_EMIT: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State machine and burst state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         open_ff    <= 1'b0;
         supp_ff    <= 1'b0;
         start_ff   <= '0;
         warm_ff    <= '0;
         peak_ff    <= '0;
         flr_ff     <= '0;
         len_ff     <= '0;
         sps_ff     <= 8'd1;
         fill_ff    <= '0;
         sum_ff     <= '0;
         closing_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         open_ff    <= open_in;
         supp_ff    <= supp_in;
         start_ff   <= start_in;
         warm_ff    <= warm_in;
         peak_ff    <= peak_in;
         flr_ff     <= flr_in;
         len_ff     <= len_in;
         sps_ff     <= sps_in;
         fill_ff    <= fill_in;
         sum_ff     <= sum_in;
         closing_ff <= closing_in;
      end
   end

   // Working datapath registers.
   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      m_ff     <= m_in;
      idx_ff   <= idx_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      bin_ff   <= bin_in;
      bsum_ff  <= bsum_in;
      half_ff  <= half_in;
      v_ff     <= v_in;
      bpeak_ff <= bpeak_in;
      env_ff   <= env_in;
   end

   assign in_ready           = state_ff == ST_IDLE;
   assign res.valid          = state_ff == ST_EMIT;
   assign res.start_ms       = start_ff;
   assign res.duration_ms    = dur[15:0];
   assign res.top_sig_lvl    = peak_ff;
   assign res.open_noise_lvl = flr_ff;
   assign res.band           = cfg.band_id;
   assign res.envelope       = env_ff;

   `RBED_ASSERT(a_len_bound, clock, reset, len_ff <= LW'(rbed_pkg::RAW_DEPTH), "store length past depth")
   `RBED_ASSERT(a_sps_pow2, clock, reset, $onehot(sps_ff), "slot width not a power of two")
   `RBED_ASSERT_IMP(a_fill_below, clock, reset, state_ff == ST_IDLE, fill_ff < sps_ff, "slot overfilled at rest")

endmodule
